FILE: rtl/wsfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared types and constants for the parser and its output stage.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5
    } t_phase;

    // Result kinds
    typedef enum logic [2:0] {
        EV_DATA      = 3'd0,
        EV_EMPTY_END = 3'd1,
        EV_PONG      = 3'd2,
        EV_MASK_ERR  = 3'd3,
        EV_TOO_LARGE = 3'd4
    } t_event_kind;

    // One result word
    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        eom;
    } t_event;

    // Frame opcodes
    localparam logic [3:0] OP_CONT = 4'd0;
    localparam logic [3:0] OP_TEXT = 4'd1;
    localparam logic [3:0] OP_BIN  = 4'd2;
    localparam logic [3:0] OP_PING = 4'd9;

    // Length codes of the second header byte
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;

    // Configuration register indexes
    localparam logic CFG_REQUIRE_MASK = 1'b0;
    localparam logic CFG_MAX_SIZE     = 1'b1;

    // Configuration reset values
    localparam logic        REQUIRE_MASK_RESET = 1'b1;
    localparam logic [31:0] MAX_SIZE_RESET     = 32'd33554432;

endpackage : wsfr_pkg
`default_nettype wire

FILE: rtl/websocket_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Parses a received byte stream into unmasked payload words and events.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the rx channel while the output stage has room
// and gives at most one result word per byte on the ev channel: payload bytes
// (unmasked, tagged with the message opcode and an end-of-message flag), an
// empty message end, a pong request, or a mask or size error after which the
// block ignores all bytes until reset. The parser state machine handles each
// byte; its result is registered in the output register, or in the skid entry
// while that register holds a waiting word. A two-word output stage lets the
// parser keep taking bytes while a result waits, so the sustained rate is one
// byte per cycle whenever the consumer keeps up. Configuration writes (index 0
// require_mask, index 1 max_message_size) are always ready and registered.
// ----------------------------------------------------------------------------
module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_ev_valid,
    input  wire logic        i_ev_ready,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_data_byte,
    output logic [3:0]       o_message_opcode,
    output logic             o_end_of_message,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic   take;
    logic   room;
    logic   par_valid;
    t_event par_event;
    t_event out_event;

    assign o_rx_ready  = room;
    assign take        = i_rx_valid & room;
    assign o_cfg_ready = 1'b1;

    // Parse one byte per accepted word
    wsfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_rx_byte),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ev_valid  (par_valid),
        .o_event     (par_event)
    );

    // Hold results for the consumer
    wsfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (par_valid),
        .i_event (par_event),
        .o_room  (room),
        .o_valid (o_ev_valid),
        .i_ready (i_ev_ready),
        .o_event (out_event)
    );

    assign o_event_kind     = out_event.kind;
    assign o_data_byte      = out_event.data;
    assign o_message_opcode = out_event.opcode;
    assign o_end_of_message = out_event.eom;

endmodule : websocket_frame_receiver
`default_nettype wire

FILE: rtl/wsfr_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame receiver output stage
// Output register plus one skid entry; ready toward the parser is registered.
// ----------------------------------------------------------------------------
module wsfr_out_stage
    import wsfr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_event i_event,
    output logic        o_room,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_event      o_event
);

    logic   r_out_valid;
    logic   r_skid_valid;
    t_event r_out;
    t_event r_skid;
    logic   pop;

    assign pop     = r_out_valid & i_ready;
    assign o_room  = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_event = r_out;

    // Load output register, park a word in the skid entry when blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out       <= i_event;
                r_out_valid <= 1'b1;
            end else if (pop) begin
                if (r_skid_valid) begin
                    r_out  <= r_skid;
                    r_skid <= i_event;
                end else begin
                    r_out <= i_event;
                end
            end else begin
                r_skid       <= i_event;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out        <= r_skid;
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

endmodule : wsfr_out_stage
`default_nettype wire

FILE: rtl/wsfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Advances the frame state machine one byte a cycle on i_take, forming the result.
// ----------------------------------------------------------------------------
module wsfr_parser
    import wsfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_cfg_write,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_ev_valid,
    output t_event           o_event
);

    t_phase      r_phase, n_phase;
    logic        r_final, n_final;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [2:0]  r_count, n_count;
    logic [63:0] r_length, n_length;
    logic [31:0] r_key, n_key;
    logic [63:0] r_index, n_index;
    logic [31:0] r_msg_len, n_msg_len;
    logic [3:0]  r_msg_kind, n_msg_kind;
    logic        r_skip, n_skip;
    logic        r_require_mask;
    logic [31:0] r_max_size;

    logic        len_done;
    logic        hdr_done;
    logic [63:0] new_len;
    logic [63:0] hdr_len;
    logic [32:0] len_sum;
    logic        too_big;
    logic        last;
    logic [7:0]  key_byte;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_mask <= REQUIRE_MASK_RESET;
            r_max_size     <= MAX_SIZE_RESET;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_REQUIRE_MASK: r_require_mask <= i_cfg_data[0];
                CFG_MAX_SIZE:     r_max_size     <= i_cfg_data;
                default:          r_max_size     <= r_max_size;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_final    <= 1'b0;
            r_opcode   <= OP_CONT;
            r_masked   <= 1'b0;
            r_count    <= 3'd0;
            r_length   <= 64'd0;
            r_key      <= 32'd0;
            r_index    <= 64'd0;
            r_msg_len  <= 32'd0;
            r_msg_kind <= 4'd0;
            r_skip     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_final    <= n_final;
            r_opcode   <= n_opcode;
            r_masked   <= n_masked;
            r_count    <= n_count;
            r_length   <= n_length;
            r_key      <= n_key;
            r_index    <= n_index;
            r_msg_len  <= n_msg_len;
            r_msg_kind <= n_msg_kind;
            r_skip     <= n_skip;
        end
    end

    // Message limit check: any length above 32 bits always overflows the limit
    assign len_sum = {1'b0, new_len[31:0]} + {1'b0, r_msg_len};
    assign too_big = (|new_len[63:32]) || (len_sum >= {1'b0, r_max_size});

    // Payload position
    assign last = ((r_index + 64'd1) == r_length);

    // Select key byte, first received byte first
    always_comb begin
        case (r_index[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Next state and result
    always_comb begin
        n_phase    = r_phase;
        n_final    = r_final;
        n_opcode   = r_opcode;
        n_masked   = r_masked;
        n_count    = r_count;
        n_length   = r_length;
        n_key      = r_key;
        n_index    = r_index;
        n_msg_len  = r_msg_len;
        n_msg_kind = r_msg_kind;
        n_skip     = r_skip;
        len_done   = 1'b0;
        hdr_done   = 1'b0;
        new_len    = r_length;
        hdr_len    = r_length;
        o_ev_valid = 1'b0;
        o_event    = '0;

        if (i_take) begin
            case (r_phase)
                PH_HDR0: begin
                    n_final  = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_skip   = !((i_byte[3:0] == OP_CONT) || (i_byte[3:0] == OP_TEXT) ||
                                 (i_byte[3:0] == OP_BIN));
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_byte[7];
                    if (!r_skip && r_require_mask && !i_byte[7]) begin
                        n_phase      = PH_CLOSED;
                        o_ev_valid   = 1'b1;
                        o_event.kind = EV_MASK_ERR;
                    end else begin
                        if (r_opcode == OP_PING) begin
                            o_ev_valid   = 1'b1;
                            o_event.kind = EV_PONG;
                        end
                        n_length = 64'd0;
                        if (i_byte[6:0] == LEN_CODE16) begin
                            n_count = 3'd1;
                            n_phase = PH_EXTLEN;
                        end else if (i_byte[6:0] == LEN_CODE64) begin
                            n_count = 3'd7;
                            n_phase = PH_EXTLEN;
                        end else begin
                            new_len  = {57'd0, i_byte[6:0]};
                            n_length = new_len;
                            len_done = 1'b1;
                        end
                    end
                end
                PH_EXTLEN: begin
                    new_len  = {r_length[55:0], i_byte};
                    n_length = new_len;
                    if (r_count == 3'd0) begin
                        len_done = 1'b1;
                    end else begin
                        n_count = r_count - 3'd1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_count == 3'd0) begin
                        hdr_done = 1'b1;
                    end else begin
                        n_count = r_count - 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    if (!r_skip) begin
                        o_ev_valid     = 1'b1;
                        o_event.kind   = EV_DATA;
                        o_event.data   = r_masked ? (i_byte ^ key_byte) : i_byte;
                        o_event.opcode = r_msg_kind;
                        o_event.eom    = last && r_final;
                    end
                    n_index = r_index + 64'd1;
                    if (last) begin
                        if (!r_skip && r_final) begin
                            n_msg_len  = 32'd0;
                            n_msg_kind = 4'd0;
                        end
                        n_phase = PH_HDR0;
                    end
                end
                PH_CLOSED: begin
                    n_phase = PH_CLOSED;
                end
                default: begin
                    n_phase = PH_CLOSED;
                end
            endcase
        end

        // Frame length known: check the limit, then go to the key or finish the header
        if (len_done) begin
            hdr_len = new_len;
            if (!r_skip && too_big) begin
                n_phase      = PH_CLOSED;
                o_ev_valid   = 1'b1;
                o_event.kind = EV_TOO_LARGE;
            end else begin
                if (!r_skip) begin
                    n_msg_len = len_sum[31:0];
                    if ((r_msg_kind == 4'd0) && (r_opcode != OP_CONT)) begin
                        n_msg_kind = r_opcode;
                    end
                end
                if (n_masked) begin
                    n_key   = 32'd0;
                    n_count = 3'd3;
                    n_phase = PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end
        end

        // Header complete: empty frame ends here, else start payload
        if (hdr_done) begin
            if (hdr_len == 64'd0) begin
                if (!r_skip && r_final) begin
                    o_ev_valid     = 1'b1;
                    o_event.kind   = EV_EMPTY_END;
                    o_event.opcode = n_msg_kind;
                    o_event.eom    = 1'b1;
                    n_msg_len      = 32'd0;
                    n_msg_kind     = 4'd0;
                end
                n_phase = PH_HDR0;
            end else begin
                n_index = 64'd0;
                n_phase = PH_PAYLOAD;
            end
        end
    end

endmodule : wsfr_parser
`default_nettype wire

FILE: test/websocket_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Streams WebSocket frames into the receiver one byte per word. A scoreboard
// parses the same bytes and predicts every result word, and each result is
// checked against that prediction. The run opens with a short directed set,
// then goes through random frames under several register settings and idle
// patterns, and ends with one protocol error that closes the block.
// ----------------------------------------------------------------------------
import wsfr_pkg::*;

// Parse the byte stream in step with the block and hold the predicted events
class deframer_scoreboard;
    logic        req_mask;
    logic [31:0] size_limit;
    t_phase      phase;
    logic        fin;
    logic [3:0]  frame_op;
    logic        masked;
    logic [2:0]  field_left;
    logic [63:0] frame_len;
    logic [31:0] key;
    logic [63:0] pay_idx;
    logic [31:0] msg_len;
    logic [3:0]  msg_op;
    logic        skip;
    t_event      pending_events[$];
    int          checked;
    int          errors;

    function new();
        req_mask   = REQUIRE_MASK_RESET;
        size_limit = MAX_SIZE_RESET;
        phase      = PH_HDR0;
        fin        = 1'b0;
        frame_op   = OP_CONT;
        masked     = 1'b0;
        field_left = 3'd0;
        frame_len  = 64'd0;
        key        = 32'd0;
        pay_idx    = 64'd0;
        msg_len    = 32'd0;
        msg_op     = OP_CONT;
        skip       = 1'b0;
        checked    = 0;
        errors     = 0;
    endfunction

    function void apply_reg(logic idx, logic [31:0] val);
        if (idx == CFG_REQUIRE_MASK) begin
            req_mask = val[0];
        end else begin
            size_limit = val;
        end
    endfunction

    function void queue_event(t_event_kind k, logic [7:0] d, logic [3:0] o, logic e);
        t_event ev;
        ev.kind   = k;
        ev.data   = d;
        ev.opcode = o;
        ev.eom    = e;
        pending_events.push_back(ev);
    endfunction

    // Finish the header: empty end marker or enter the payload
    function void header_done();
        if (frame_len == 64'd0) begin
            if (!skip && fin) begin
                queue_event(EV_EMPTY_END, 8'd0, msg_op, 1'b1);
                msg_len = 32'd0;
                msg_op  = OP_CONT;
            end
            phase = PH_HDR0;
        end else begin
            pay_idx = 64'd0;
            phase   = PH_PAYLOAD;
        end
    endfunction

    // Check the size limit, take the message opcode, then go to the key or finish the header
    function void length_known();
        if (!skip) begin
            if (msg_len >= size_limit || frame_len >= {32'd0, size_limit - msg_len}) begin
                phase = PH_CLOSED;
                queue_event(EV_TOO_LARGE, 8'd0, 4'd0, 1'b0);
                return;
            end
            msg_len = msg_len + frame_len[31:0];
            if (msg_op == OP_CONT && frame_op != OP_CONT) msg_op = frame_op;
        end
        if (masked) begin
            key        = 32'd0;
            field_left = 3'd3;
            phase      = PH_KEY;
        end else begin
            header_done();
        end
    endfunction

    function void note_byte(logic [7:0] b);
        logic       last_byte;
        logic [7:0] v;
        int         sel;
        case (phase)
            PH_HDR0: begin
                fin      = b[7];
                frame_op = b[3:0];
                skip     = !(frame_op == OP_CONT || frame_op == OP_TEXT || frame_op == OP_BIN);
                phase    = PH_HDR1;
            end
            PH_HDR1: begin
                masked = b[7];
                if (!skip && req_mask && !masked) begin
                    phase = PH_CLOSED;
                    queue_event(EV_MASK_ERR, 8'd0, 4'd0, 1'b0);
                    return;
                end
                if (frame_op == OP_PING) queue_event(EV_PONG, 8'd0, 4'd0, 1'b0);
                frame_len = 64'd0;
                if (b[6:0] == LEN_CODE16) begin
                    field_left = 3'd1;
                    phase      = PH_EXTLEN;
                end else if (b[6:0] == LEN_CODE64) begin
                    field_left = 3'd7;
                    phase      = PH_EXTLEN;
                end else begin
                    frame_len = {57'd0, b[6:0]};
                    length_known();
                end
            end
            PH_EXTLEN: begin
                frame_len = {frame_len[55:0], b};
                if (field_left == 3'd0) length_known();
                else field_left = field_left - 3'd1;
            end
            PH_KEY: begin
                key = {key[23:0], b};
                if (field_left == 3'd0) header_done();
                else field_left = field_left - 3'd1;
            end
            PH_PAYLOAD: begin
                last_byte = (pay_idx + 64'd1 == frame_len);
                if (!skip) begin
                    sel = 3 - int'(pay_idx[1:0]);
                    v   = masked ? (b ^ key[sel*8 +: 8]) : b;
                    queue_event(EV_DATA, v, msg_op, last_byte && fin);
                end
                pay_idx = pay_idx + 64'd1;
                if (last_byte) begin
                    if (!skip && fin) begin
                        msg_len = 32'd0;
                        msg_op  = OP_CONT;
                    end
                    phase = PH_HDR0;
                end
            end
            default: phase = PH_CLOSED;
        endcase
    endfunction

    // Compare one result word with the oldest prediction
    function void check_event(logic [2:0] kind, logic [7:0] data, logic [3:0] opc, logic eom);
        t_event ev;
        if (pending_events.size() == 0) begin
            $display("%0t: unexpected result kind %0d data %02h opcode %0d eom %0b",
                     $time, kind, data, opc, eom);
            errors++;
            return;
        end
        ev = pending_events.pop_front();
        checked++;
        if (kind !== ev.kind || data !== ev.data || opc !== ev.opcode || eom !== ev.eom) begin
            $display("%0t: expected k%0d d%02h op%0d eom%0b, got k%0d d%02h op%0d eom%0b",
                     $time, ev.kind, ev.data, ev.opcode, ev.eom, kind, data, opc, eom);
            errors++;
        end
    endfunction
endclass

module websocket_frame_receiver_tb;

    localparam logic [3:0] OP_CLOSE       = 4'd8;
    localparam logic [3:0] OP_PONG        = 4'd10;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         NUM_PHASES     = 8;
    localparam int         PHASE_BYTES    = 250;

    typedef enum int { FORM_SHORT, FORM_16, FORM_64 } t_len_form;
    typedef enum int { END_MASK, END_EXACT, END_HUGE } t_close_kind;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        i_ev_ready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_REQUIRE_MASK;
    logic [31:0] i_cfg_data  = 32'd0;
    logic        o_rx_ready;
    logic        o_ev_valid;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_data_byte;
    logic [3:0]  o_message_opcode;
    logic        o_end_of_message;
    logic        o_cfg_ready;

    deframer_scoreboard sb = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int bytes_sent     = 0;
    int cfg_phases     = 0;
    int quiet_cycles   = 0;
    bit in_message     = 1'b0;

    websocket_frame_receiver uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_ev_valid       (o_ev_valid),
        .i_ev_ready       (i_ev_ready),
        .o_event_kind     (o_event_kind),
        .o_data_byte      (o_data_byte),
        .o_message_opcode (o_message_opcode),
        .o_end_of_message (o_end_of_message),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_ev_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check results and watch for a stuck handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_ev_valid && i_ev_ready) begin
                sb.check_event(o_event_kind, o_data_byte, o_message_opcode, o_end_of_message);
            end
            if ((i_rx_valid && o_rx_ready) || (o_ev_valid && i_ev_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, sb.pending_events.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Send one byte word, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic fin, input logic [3:0] opc, input logic msk,
                               input t_len_form form, input logic [63:0] len);
        logic [31:0] mkey;
        mkey = $urandom;
        send_byte({fin, 3'($urandom_range(7)), opc});
        case (form)
            FORM_SHORT: send_byte({msk, len[6:0]});
            FORM_16: begin
                send_byte({msk, LEN_CODE16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({msk, LEN_CODE64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
        endcase
        if (msk) begin
            for (int i = 3; i >= 0; i--) send_byte(mkey[8*i +: 8]);
        end
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] opc, input logic msk,
                              input t_len_form form, input logic [63:0] len);
        send_header(fin, opc, msk, form, len);
        for (logic [63:0] i = 0; i < len; i++) send_byte(8'($urandom));
    endtask

    function automatic t_len_form pick_form(input logic [63:0] len);
        int unsigned r;
        r = $urandom_range(99);
        if (len <= 64'd125 && r < 70) return FORM_SHORT;
        if (r < 88) return FORM_16;
        return FORM_64;
    endfunction

    // Mostly short payloads, some empty, a few long; clip to what the limit allows
    function automatic logic [63:0] pick_len(input logic [31:0] room);
        int unsigned r;
        logic [63:0] n;
        r = $urandom_range(99);
        if (r < 10) n = 64'd0;
        else if (r < 85) n = 64'($urandom_range(1, 12));
        else n = 64'($urandom_range(13, 300));
        if (room < 32'd40 && $urandom_range(3) == 0) n = {32'd0, room};
        if (n > {32'd0, room}) n = {32'd0, room};
        return n;
    endfunction

    // One random frame that keeps the connection open
    task automatic random_frame();
        int unsigned roll;
        logic        fin;
        logic        msk;
        logic [3:0]  opc;
        logic [63:0] len;
        roll = $urandom_range(99);
        fin  = ($urandom_range(99) < 60);
        if (roll < 72) begin
            if (in_message) begin
                if ($urandom_range(9) == 0) opc = $urandom_range(1) ? OP_TEXT : OP_BIN;
                else opc = OP_CONT;
            end else begin
                if ($urandom_range(9) == 0) opc = OP_CONT;
                else opc = $urandom_range(1) ? OP_TEXT : OP_BIN;
            end
            msk = sb.req_mask ? 1'b1 : 1'($urandom_range(1));
            len = pick_len(sb.size_limit - sb.msg_len - 32'd1);
            send_frame(fin, opc, msk, pick_form(len), len);
            in_message = !fin;
        end else begin
            if (roll < 84) begin
                opc = OP_PING;
            end else begin
                do opc = 4'($urandom_range(3, 15)); while (opc == OP_PING);
            end
            msk = 1'($urandom_range(1));
            len = pick_len(32'd400);
            send_frame(fin, opc, msk, pick_form(len), len);
        end
    endtask

    // Drop valid and let every expected result drain out
    task automatic drain();
        i_rx_valid <= 1'b0;
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_reg(idx, val);
    endtask

    // Close any open message, go idle, then load both registers
    task automatic configure(input logic rm, input logic [31:0] lim);
        if (in_message) begin
            send_frame(1'b1, OP_CONT, sb.req_mask ? 1'b1 : 1'($urandom_range(1)), FORM_SHORT, 0);
            in_message = 1'b0;
        end
        drain();
        if ($urandom_range(1)) begin
            write_reg(CFG_REQUIRE_MASK, {31'd0, rm});
            write_reg(CFG_MAX_SIZE, lim);
        end else begin
            write_reg(CFG_MAX_SIZE, lim);
            write_reg(CFG_REQUIRE_MASK, {31'd0, rm});
        end
        i_cfg_valid <= 1'b0;
        cfg_phases++;
    endtask

    initial begin
        t_close_kind ending;
        int          phase_start;
        int          lim;
        int          part;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: masked text with extreme payload bytes
        send_header(1'b1, OP_TEXT, 1'b1, FORM_SHORT, 5);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'h7E);
        // Ping gives a pong request
        send_frame(1'b1, OP_PING, 1'b0, FORM_SHORT, 0);
        // Fragmented binary message with a pong and a close in the middle
        send_frame(1'b0, OP_BIN, 1'b1, FORM_16, 2);
        send_frame(1'b1, OP_PONG, 1'b0, FORM_SHORT, 1);
        send_frame(1'b1, OP_CLOSE, 1'b1, FORM_16, 1);
        send_frame(1'b1, OP_CONT, 1'b1, FORM_64, 1);
        // Empty final frame ends on its last key byte
        send_header(1'b1, OP_TEXT, 1'b1, FORM_SHORT, 0);
        // Message opened by a continuation, opcode picked up later
        send_frame(1'b0, OP_CONT, 1'b1, FORM_SHORT, 1);
        send_frame(1'b1, OP_TEXT, 1'b1, FORM_SHORT, 1);

        // Random frames under several settings and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: ;
                1: configure(1'b0, 32'hFFFF_FFFF);
                2: configure(1'b1, 32'd1);
                3: configure(1'b0, 32'($urandom_range(16, 64)));
                4: configure(1'b1, 32'hFFFF_FFFF);
                5: configure(1'b0, 32'd1);
                6: configure(1'b1, 32'($urandom_range(16, 64)));
                default: configure(1'($urandom_range(1)), MAX_SIZE_RESET);
            endcase
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent < phase_start + PHASE_BYTES) random_frame();
        end

        // End on one protocol error; the block stays closed afterwards
        ending = t_close_kind'($urandom_range(2));
        case (ending)
            END_MASK: begin
                configure(1'b1, sb.size_limit);
                send_header(1'b1, OP_TEXT, 1'b0, FORM_SHORT, 3);
            end
            END_EXACT: begin
                lim = $urandom_range(16, 64);
                configure(1'($urandom_range(1)), 32'(lim));
                part = $urandom_range(1, lim - 1);
                send_frame(1'b0, OP_TEXT, 1'b1, pick_form(64'(part)), 64'(part));
                send_header(1'b1, OP_CONT, 1'b1, pick_form(64'(lim - part)), 64'(lim - part));
            end
            default: begin
                configure(1'($urandom_range(1)), MAX_SIZE_RESET);
                send_header(1'b1, OP_BIN, 1'b1, FORM_64, {1'b1, 63'($urandom)});
            end
        endcase
        // Everything after the error is ignored
        repeat (16) send_byte(8'($urandom));
        drain();
        repeat (4) @(posedge i_clk);

        if (sb.pending_events.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, sb.pending_events.size());
            sb.errors++;
        end
        $display("Sent %0d bytes over %0d register settings, checked %0d result words",
                 bytes_sent, cfg_phases, sb.checked);
        $display("Stream closed by %s", ending.name());
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
